// ===== rtl/sws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sws_pkg
// Shared types and codes for the stack with sorted insert.
// ============================================================================
package sws_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int ERR_W     = 2;
    localparam int COUNT_W   = 5;
    localparam int DEPTH_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] t_data;

    // Broadcast to every cell; strobes only set for a command that changes the stack.
    typedef struct packed {
        logic  push;
        logic  insert;
        logic  pop;
        t_data value;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== rtl/sws_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sws_cmd_if / sws_rsp_if
// Valid/ready channels for commands and results.
// ============================================================================
interface sws_cmd_if import sws_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    t_data             value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sws_rsp_if import sws_pkg::*; ();
    logic               valid;
    logic               ready;
    t_data              popped_value;
    logic               pop_valid;
    logic [ERR_W-1:0]   error_code;
    logic [COUNT_W-1:0] entry_count;
    logic               not_empty;

    modport source (output valid, output popped_value, output pop_valid,
                    output error_code, output entry_count, output not_empty,
                    input ready);
    modport sink   (input valid, input popped_value, input pop_valid,
                    input error_code, input entry_count, input not_empty,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/sws_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sws_cell
// One stack slot. Slot 0 is the top; data moves one slot per command.
// ============================================================================
module sws_cell import sws_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire logic       i_before,     // every slot nearer the top is valid and smaller
    input  wire t_data      i_up_data,
    input  wire logic       i_up_valid,
    input  wire t_data      i_down_data,
    input  wire logic       i_down_valid,
    output logic            o_before,
    output t_data           o_data,
    output logic            o_valid
);

    t_data r_data;
    t_data n_data;
    logic  r_valid;
    logic  n_valid;
    logic  w_lt;

    assign w_lt     = r_valid && (r_data < i_ctrl.value);
    assign o_before = i_before && w_lt;
    assign o_data   = r_data;
    assign o_valid  = r_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.push) begin
            n_data  = i_up_data;
            n_valid = i_up_valid;
        end else if (i_ctrl.insert) begin
            n_valid = i_up_valid;
            if (!i_before) begin
                n_data = i_up_data;
            end else if (!w_lt) begin
                n_data = i_ctrl.value;
            end
        end else if (i_ctrl.pop) begin
            n_data  = i_down_data;
            n_valid = i_down_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule
`default_nettype wire

// ===== rtl/stack_with_sorted_insert_core.sv =====
// ----------------------------------------------------------------------------
// stack_with_sorted_insert_core
// Bounded LIFO of signed 32-bit values with push, ordered insert and pop.
// Commands arrive on i_cmd (cmd, value); each yields one result on o_rsp
// (popped_value, pop_valid, error_code, entry_count, not_empty).
// The stack is a row of DEPTH cells with slot 0 on top. Every cell compares
// its entry with the incoming value in parallel; the ordered-insert position
// ripples down the row and all cells shift in the same cycle.
// Throughput: one command per cycle while o_rsp is not stalled. The result
// is registered and valid in the cycle after the command transaction.
// Pop on empty returns error 1 with no change; push or insert on a full
// stack is dropped with error 2; command code 3 changes nothing.
// When o_rsp is stalled the held result stays put and i_cmd.ready drops
// until it is taken; a command is taken in the same cycle the result leaves.
// Reset empties the stack at once; cell contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// stack_with_sorted_insert_core
// Top level: command decode, cell row, count and result register.
// ============================================================================
module stack_with_sorted_insert_core import sws_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sws_cmd_if.sink     i_cmd,
    sws_rsp_if.source   o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cell_ctrl          w_ctrl;
    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    logic [ERR_W-1:0]    w_err;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [CNT_W+COUNT_W-1:0] w_count_ext;

    logic                r_rsp_valid;
    t_data               r_popped;
    logic                r_pop_valid;
    logic [ERR_W-1:0]    r_err;
    logic [COUNT_W-1:0]  r_entry_count;
    logic                r_not_empty;

    t_data               w_data   [DEPTH];
    logic                w_valid  [DEPTH];
    logic                w_before [DEPTH+1];

    assign i_cmd.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = w_valid[DEPTH-1];
    assign w_empty     = !w_valid[0];

    always_comb begin
        w_ctrl        = '0;
        w_ctrl.value  = i_cmd.value;
        w_err         = ERR_OK;
        n_count       = r_count;
        case (i_cmd.cmd)
            CMD_PUSH, CMD_INSERT: begin
                if (w_full) begin
                    w_err = ERR_FULL;
                end else begin
                    w_ctrl.push   = w_accept && (i_cmd.cmd == CMD_PUSH);
                    w_ctrl.insert = w_accept && (i_cmd.cmd == CMD_INSERT);
                    n_count       = r_count + CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (w_empty) begin
                    w_err = ERR_EMPTY;
                end else begin
                    w_ctrl.pop = w_accept;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_err = ERR_OK;
            end
        endcase
    end

    assign w_before[0] = 1'b1;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_data w_up_data;
        logic  w_up_valid;
        t_data w_down_data;
        logic  w_down_valid;

        if (g == 0) begin : g_top
            assign w_up_data  = i_cmd.value;
            assign w_up_valid = 1'b1;
        end else begin : g_mid
            assign w_up_data  = w_data[g-1];
            assign w_up_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_bottom
            assign w_down_data  = '0;
            assign w_down_valid = 1'b0;
        end else begin : g_inner
            assign w_down_data  = w_data[g+1];
            assign w_down_valid = w_valid[g+1];
        end

        sws_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_before     (w_before[g]),
            .i_up_data    (w_up_data),
            .i_up_valid   (w_up_valid),
            .i_down_data  (w_down_data),
            .i_down_valid (w_down_valid),
            .o_before     (w_before[g+1]),
            .o_data       (w_data[g]),
            .o_valid      (w_valid[g])
        );
    end

    assign w_count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped      <= w_ctrl.pop ? w_data[0] : '0;
            r_pop_valid   <= w_ctrl.pop;
            r_err         <= w_err;
            r_entry_count <= w_count_ext[COUNT_W-1:0];
            r_not_empty   <= (n_count != '0);
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.popped_value = r_popped;
    assign o_rsp.pop_valid    = r_pop_valid;
    assign o_rsp.error_code   = r_err;
    assign o_rsp.entry_count  = r_entry_count;
    assign o_rsp.not_empty    = r_not_empty;

endmodule
`default_nettype wire
